// ===== src/gtal_pkg.sv =====
package gtal_pkg;

    // Alarm levels, in increasing severity.
    typedef enum logic [2:0] {
        LVL_NONE  = 3'd0,
        LVL_ATTN  = 3'd1,
        LVL_ONE   = 3'd2,
        LVL_TWO   = 3'd3,
        LVL_THREE = 3'd4
    } t_level;

    // Request commands carried in tuser.
    typedef enum logic [1:0] {
        CMD_EVAL  = 2'd0,
        CMD_FORCE = 2'd1,
        CMD_MUTE  = 2'd2,
        CMD_RESET = 2'd3
    } t_cmd;

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_WARN_ENTER     = 3'd0;
    localparam logic [2:0] REG_DANGER_ENTER   = 3'd1;
    localparam logic [2:0] REG_CRITICAL_ENTER = 3'd2;
    localparam logic [2:0] REG_CRITICAL_EXIT  = 3'd3;
    localparam logic [2:0] REG_DANGER_EXIT    = 3'd4;
    localparam logic [2:0] REG_WARN_EXIT      = 3'd5;
    localparam logic [2:0] REG_TEMP_WARN      = 3'd6;
    localparam logic [2:0] REG_TEMP_DANGER    = 3'd7;

    localparam int GAS_W  = 12;
    localparam int TEMP_W = 16;
    localparam int CNT_W  = 4;
    localparam int FAN_W  = 7;

    localparam logic [GAS_W-1:0] FORCED_GAS = 12'd999;

    typedef struct packed {
        logic [GAS_W-1:0]  warn_enter;
        logic [GAS_W-1:0]  danger_enter;
        logic [GAS_W-1:0]  critical_enter;
        logic [GAS_W-1:0]  critical_exit;
        logic [GAS_W-1:0]  danger_exit;
        logic [GAS_W-1:0]  warn_exit;
        logic [TEMP_W-1:0] temp_warn;
        logic [TEMP_W-1:0] temp_danger;
    } t_cfg;

    typedef struct packed {
        t_level           level;
        logic [CNT_W-1:0] count;
        logic             forced;
        logic             muted;
    } t_state;

    // Result item; level sits in the lowest bits when packed into tdata.
    typedef struct packed {
        logic [GAS_W-1:0] event_gas;
        logic             alarm_event;
        logic [FAN_W-1:0] fan_percent;
        logic             buzzer;
        logic             red_led;
        logic             green_led;
        logic             muted;
        t_level           level;
    } t_result;

    function automatic logic [FAN_W-1:0] fan_for(t_level lvl);
        logic [FAN_W-1:0] f;
        case (lvl)
            LVL_NONE: f = 7'd20;
            LVL_ATTN: f = 7'd40;
            LVL_ONE:  f = 7'd60;
            LVL_TWO:  f = 7'd80;
            default:  f = 7'd100;
        endcase
        return f;
    endfunction

endpackage

// ===== src/gtal_step.sv =====
module gtal_step import gtal_pkg::*; #(
    parameter int ATTENTION_ENTER = 200,
    parameter int ATTENTION_EXIT  = 180,
    parameter int STARTUP_HOLD_MS = 30000,
    parameter int CONFIRM_COUNT   = 3,
    parameter int COUNT_LIMIT     = 10
) (
    input  t_cfg               i_cfg,
    input  t_state             i_state,
    input  t_cmd               i_cmd,
    input  logic [GAS_W-1:0]   i_gas,
    input  logic [TEMP_W-1:0]  i_temp,
    input  logic [31:0]        i_uptime,
    output t_state             o_state,
    output t_result            o_result
);

    logic signed [TEMP_W-1:0] temp;
    logic signed [TEMP_W-1:0] warn_temp;
    logic signed [TEMP_W-1:0] danger_temp;
    t_level                   next_lvl;
    logic [CNT_W-1:0]         cnt;
    logic                     evt;
    logic [GAS_W-1:0]         ev_gas;
    t_state                   st;

    assign temp        = $signed(i_temp);
    assign warn_temp   = $signed(i_cfg.temp_warn);
    assign danger_temp = $signed(i_cfg.temp_danger);

    always_comb begin
        st       = i_state;
        next_lvl = i_state.level;
        cnt      = i_state.count;
        evt      = 1'b0;
        ev_gas   = '0;
        case (i_cmd)
            CMD_EVAL: begin
                if (i_state.forced) begin
                    next_lvl = LVL_THREE;
                end else if (i_uptime < 32'(STARTUP_HOLD_MS)) begin
                    next_lvl = LVL_NONE;
                    cnt      = '0;
                end else begin
                    // The confirm count saturates and clears with hysteresis.
                    if (i_gas >= i_cfg.critical_enter) begin
                        if (cnt < CNT_W'(COUNT_LIMIT)) begin
                            cnt = cnt + 1'b1;
                        end
                    end else if (i_gas <= i_cfg.critical_exit) begin
                        cnt = '0;
                    end
                    if (cnt >= CNT_W'(CONFIRM_COUNT) ||
                        (i_state.level == LVL_THREE && i_gas > i_cfg.critical_exit)) begin
                        next_lvl = LVL_THREE;
                    end else if (i_gas >= i_cfg.danger_enter || temp >= danger_temp) begin
                        next_lvl = LVL_TWO;
                    end else if (i_state.level == LVL_TWO &&
                                 (i_gas > i_cfg.danger_exit || temp >= warn_temp)) begin
                        next_lvl = LVL_TWO;
                    end else if (i_gas >= i_cfg.warn_enter || temp >= warn_temp) begin
                        next_lvl = LVL_ONE;
                    end else if (i_state.level == LVL_ONE && i_gas > i_cfg.warn_exit) begin
                        next_lvl = LVL_ONE;
                    end else if (i_gas >= GAS_W'(ATTENTION_ENTER)) begin
                        next_lvl = LVL_ATTN;
                    end else if (i_state.level == LVL_ATTN &&
                                 i_gas > GAS_W'(ATTENTION_EXIT)) begin
                        next_lvl = LVL_ATTN;
                    end else begin
                        next_lvl = LVL_NONE;
                    end
                end
                st.count = cnt;
                if (next_lvl != i_state.level) begin
                    st.muted = 1'b0;
                    st.level = next_lvl;
                    if (next_lvl >= LVL_TWO) begin
                        evt    = 1'b1;
                        ev_gas = i_gas;
                    end
                end
            end
            CMD_FORCE: begin
                st.forced = 1'b1;
                st.muted  = 1'b0;
                st.level  = LVL_THREE;
                evt       = 1'b1;
                ev_gas    = FORCED_GAS;
            end
            CMD_MUTE: begin
                if (i_state.level >= LVL_THREE) begin
                    st.muted = 1'b1;
                end
            end
            default: begin
                st.forced = 1'b0;
                st.muted  = 1'b0;
                st.level  = LVL_NONE;
                st.count  = '0;
            end
        endcase
    end

    assign o_state = st;

    always_comb begin
        o_result.level       = st.level;
        o_result.muted       = st.muted;
        o_result.green_led   = (st.level == LVL_NONE);
        o_result.red_led     = (st.level >= LVL_TWO);
        o_result.buzzer      = (st.level >= LVL_THREE) && !st.muted;
        o_result.fan_percent = fan_for(st.level);
        o_result.alarm_event = evt;
        o_result.event_gas   = ev_gas;
    end

endmodule

// ===== src/gas_temp_alarm_level_fsm_unit.sv =====
// A request is taken into the input register, and its result moves on into the result
// register that drives m_axis, unless a result that is still waiting holds the pipeline.
// Throughput: one request per cycle while no waiting result holds the pipeline; the single
// state update sits between the input register and the result register.
// Reset: i_rst_n is synchronous and active low; it empties both pipeline registers, clears
// the alarm state and loads the threshold registers with their default values.
module gas_temp_alarm_level_fsm_unit import gtal_pkg::*; #(
    parameter int ATTENTION_ENTER = 200,
    parameter int ATTENTION_EXIT  = 180,
    parameter int STARTUP_HOLD_MS = 30000,
    parameter int CONFIRM_COUNT   = 3,
    parameter int COUNT_LIMIT     = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: gas_reading[11:0], temp_tenths[27:12], uptime[59:28], zero pad[63:60]
    input  logic [63:0] s_axis_tdata,
    // tuser: command[1:0]
    input  logic [1:0]  s_axis_tuser,
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: level[2:0], muted[3], green_led[4], red_led[5], buzzer[6],
    //        fan_percent[13:7], alarm_event[14], event_gas[26:15], zero pad[31:27]
    output logic [31:0] m_axis_tdata
);

    // Threshold registers; the user writes them through the configuration port when idle.
    t_cfg r_cfg;
    logic [2:0] reg_idx;
    logic       cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.warn_enter     <= 12'd300;
            r_cfg.danger_enter   <= 12'd500;
            r_cfg.critical_enter <= 12'd700;
            r_cfg.critical_exit  <= 12'd650;
            r_cfg.danger_exit    <= 12'd450;
            r_cfg.warn_exit      <= 12'd250;
            r_cfg.temp_warn      <= 16'd450;
            r_cfg.temp_danger    <= 16'd600;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_WARN_ENTER:     r_cfg.warn_enter     <= pwdata[GAS_W-1:0];
                REG_DANGER_ENTER:   r_cfg.danger_enter   <= pwdata[GAS_W-1:0];
                REG_CRITICAL_ENTER: r_cfg.critical_enter <= pwdata[GAS_W-1:0];
                REG_CRITICAL_EXIT:  r_cfg.critical_exit  <= pwdata[GAS_W-1:0];
                REG_DANGER_EXIT:    r_cfg.danger_exit    <= pwdata[GAS_W-1:0];
                REG_WARN_EXIT:      r_cfg.warn_exit      <= pwdata[GAS_W-1:0];
                REG_TEMP_WARN:      r_cfg.temp_warn      <= pwdata[TEMP_W-1:0];
                REG_TEMP_DANGER:    r_cfg.temp_danger    <= pwdata[TEMP_W-1:0];
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    // Reads return the register; temperatures come back sign-extended.
    always_comb begin
        case (reg_idx)
            REG_WARN_ENTER:     prdata = {20'd0, r_cfg.warn_enter};
            REG_DANGER_ENTER:   prdata = {20'd0, r_cfg.danger_enter};
            REG_CRITICAL_ENTER: prdata = {20'd0, r_cfg.critical_enter};
            REG_CRITICAL_EXIT:  prdata = {20'd0, r_cfg.critical_exit};
            REG_DANGER_EXIT:    prdata = {20'd0, r_cfg.danger_exit};
            REG_WARN_EXIT:      prdata = {20'd0, r_cfg.warn_exit};
            REG_TEMP_WARN:      prdata = {{16{r_cfg.temp_warn[15]}}, r_cfg.temp_warn};
            REG_TEMP_DANGER:    prdata = {{16{r_cfg.temp_danger[15]}}, r_cfg.temp_danger};
            default:            prdata = '0;
        endcase
    end

    // Input register. It takes a new request whenever it is empty or its
    // content moves on to the result register in the same cycle, so a waiting
    // result stops the request side only once the input register is full too.
    logic               r_in_valid;
    t_cmd               r_cmd;
    logic [GAS_W-1:0]   r_gas;
    logic [TEMP_W-1:0]  r_temp;
    logic [31:0]        r_uptime;
    logic               adv;
    logic               take;

    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || adv;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd    <= t_cmd'(s_axis_tuser);
            r_gas    <= s_axis_tdata[11:0];
            r_temp   <= s_axis_tdata[27:12];
            r_uptime <= s_axis_tdata[59:28];
        end
    end

    // Alarm state and the level decision for the request in the input register.
    t_state  r_state;
    t_state  n_state;
    t_result n_result;

    gtal_step #(
        .ATTENTION_ENTER (ATTENTION_ENTER),
        .ATTENTION_EXIT  (ATTENTION_EXIT),
        .STARTUP_HOLD_MS (STARTUP_HOLD_MS),
        .CONFIRM_COUNT   (CONFIRM_COUNT),
        .COUNT_LIMIT     (COUNT_LIMIT)
    ) u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_cmd    (r_cmd),
        .i_gas    (r_gas),
        .i_temp   (r_temp),
        .i_uptime (r_uptime),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // The state and the result register move together, so each request sees
    // the state left by the one before it.
    logic    r_out_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '{level: LVL_NONE, count: '0, forced: 1'b0, muted: 1'b0};
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_valid) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_result};

`ifndef SYNTHESIS
    a_forced_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.forced |-> r_state.level == LVL_THREE)
        else $error("forced flag set below level3");

    a_muted_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.muted |-> r_state.level == LVL_THREE)
        else $error("mute held below level3");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.count <= CNT_W'(COUNT_LIMIT))
        else $error("confirm count above its limit");

    a_item_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && adv |=> r_out_valid)
        else $error("request lost between input and result register");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import gtal_pkg::*;

    // Block constants as the unit is built with its default parameters.
    localparam int ATTN_ENTER  = 200;
    localparam int ATTN_EXIT   = 180;
    localparam int HOLD_MS     = 30000;
    localparam int CONFIRM_NUM = 3;
    localparam int COUNT_SAT   = 10;

    // Long receiver hold used once to back the pipeline up into the request side.
    localparam int LONG_HOLD   = 400;
    // Cycles allowed after the results of each phase are back, before the next step.
    localparam int SETTLE      = 6;
    // Upper bound on the whole run; the slowest legal run stays far below it.
    localparam int CYCLE_LIMIT = 400000;

    // One request as the sender sees it, before it is packed onto the bus.
    typedef struct {
        t_cmd              cmd;
        logic [11:0]       gas;
        logic signed [15:0] temp;
        logic [31:0]       uptime;
    } t_alarm_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // tdata: gas_reading[11:0], temp_tenths[27:12], uptime[59:28], zero pad[63:60]
    logic [63:0] s_axis_tdata = '0;
    // tuser: command[1:0]
    logic [1:0]  s_axis_tuser = '0;

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // tdata: level[2:0], muted[3], green_led[4], red_led[5], buzzer[6],
    //        fan_percent[13:7], alarm_event[14], event_gas[26:15], zero pad[31:27]
    logic [31:0] m_axis_tdata;

    gas_temp_alarm_level_fsm_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Requests waiting to be driven, and results the alarm logic should produce, oldest first.
    t_alarm_req alarm_req_q[$];
    t_result    alarm_expect_q[$];

    // Shadow copy of the threshold registers.
    logic [11:0]        thr_warn_enter;
    logic [11:0]        thr_danger_enter;
    logic [11:0]        thr_crit_enter;
    logic [11:0]        thr_crit_exit;
    logic [11:0]        thr_danger_exit;
    logic [11:0]        thr_warn_exit;
    logic signed [15:0] thr_temp_warn;
    logic signed [15:0] thr_temp_danger;

    // Shadow copy of the alarm state.
    t_level     st_level;
    logic [3:0] st_count;
    logic       st_forced;
    logic       st_muted;

    // Idle controls for both sides and the one long receiver hold.
    logic tx_idle_en = 1'b1;
    logic rx_idle_en = 1'b1;
    logic hold_request = 1'b0;
    logic hold_done = 1'b0;
    int   hold_cycles = 0;
    int   tx_gap = 0;
    int   rx_gap = 0;

    int errors = 0;
    int cycle_count = 0;
    int requests_sent = 0;
    int results_checked = 0;
    int events_seen = 0;
    int level3_seen = 0;
    int settings_used = 1;

    // Gas and temperature judgement for an evaluate request once the startup hold is over.
    // The critical count moves first, then the levels are tried from the top down, each
    // with its enter condition and then its hold condition.
    function automatic t_level grade_reading(logic [11:0] gas, logic signed [15:0] temp);
        if (gas >= thr_crit_enter) begin
            if (st_count < COUNT_SAT) st_count++;
        end else if (gas <= thr_crit_exit) begin
            st_count = '0;
        end
        if (st_count >= CONFIRM_NUM || (st_level == LVL_THREE && gas > thr_crit_exit))
            return LVL_THREE;
        if (gas >= thr_danger_enter || temp >= thr_temp_danger) return LVL_TWO;
        if (st_level == LVL_TWO && (gas > thr_danger_exit || temp >= thr_temp_warn))
            return LVL_TWO;
        if (gas >= thr_warn_enter || temp >= thr_temp_warn) return LVL_ONE;
        if (st_level == LVL_ONE && gas > thr_warn_exit) return LVL_ONE;
        if (gas >= ATTN_ENTER) return LVL_ATTN;
        if (st_level == LVL_ATTN && gas > ATTN_EXIT) return LVL_ATTN;
        return LVL_NONE;
    endfunction

    // Applies one request to the shadow state and returns the result it should produce.
    function automatic t_result step_alarm(t_alarm_req rq);
        t_result     r;
        t_level      nxt;
        logic        evt;
        logic [11:0] evg;
        evt = 1'b0;
        evg = '0;
        case (rq.cmd)
            CMD_EVAL: begin
                if (st_forced) begin
                    nxt = LVL_THREE;
                end else if (rq.uptime < HOLD_MS) begin
                    nxt = LVL_NONE;
                    st_count = '0;
                end else begin
                    nxt = grade_reading(rq.gas, rq.temp);
                end
                // Any change of level unmutes; only a change that lands on level2 or above is an event.
                if (nxt != st_level) begin
                    st_muted = 1'b0;
                    st_level = nxt;
                    if (nxt >= LVL_TWO) begin
                        evt = 1'b1;
                        evg = rq.gas;
                    end
                end
            end
            CMD_FORCE: begin
                st_forced = 1'b1;
                st_muted = 1'b0;
                st_level = LVL_THREE;
                evt = 1'b1;
                evg = FORCED_GAS;
            end
            CMD_MUTE: begin
                if (st_level >= LVL_THREE) st_muted = 1'b1;
            end
            default: begin
                st_forced = 1'b0;
                st_muted = 1'b0;
                st_level = LVL_NONE;
                st_count = '0;
            end
        endcase
        r.level = st_level;
        r.muted = st_muted;
        r.green_led = (st_level == LVL_NONE);
        r.red_led = (st_level >= LVL_TWO);
        r.buzzer = (st_level >= LVL_THREE) && !st_muted;
        r.fan_percent = 7'(20 * (int'(st_level) + 1));
        r.alarm_event = evt;
        r.event_gas = evg;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Request driver. A request that is offered stays on the bus until it is taken;
    // in between requests the sender may pause at random.
    always @(posedge i_clk) begin : request_driver
        t_alarm_req rq;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap <= 0;
        end else if (!(s_axis_tvalid && !s_axis_tready)) begin
            if (tx_gap != 0) begin
                tx_gap <= tx_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (tx_idle_en && $urandom_range(0, 7) == 0) begin
                tx_gap <= $urandom_range(0, 15);
                s_axis_tvalid <= 1'b0;
            end else if (alarm_req_q.size() != 0) begin
                rq = alarm_req_q.pop_front();
                s_axis_tdata <= {4'b0, rq.uptime, rq.temp, rq.gas};
                s_axis_tuser <= rq.cmd;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver. Besides short random stalls it holds off once for a long stretch,
    // so that the unit fills up and has to drop s_axis_tready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_gap <= 0;
        end else if (hold_request && !hold_done) begin
            m_axis_tready <= 1'b0;
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles == LONG_HOLD - 1) hold_done <= 1'b1;
        end else if (rx_gap != 0) begin
            rx_gap <= rx_gap - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
            rx_gap <= $urandom_range(0, 15);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor. Every accepted request is run through the shadow state to get its
    // expected result; every accepted result is checked against the oldest expectation.
    always @(posedge i_clk) begin : result_monitor
        t_alarm_req rq;
        t_result    want;
        t_result    got;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                rq.cmd = t_cmd'(s_axis_tuser);
                rq.gas = s_axis_tdata[11:0];
                rq.temp = s_axis_tdata[27:12];
                rq.uptime = s_axis_tdata[59:28];
                alarm_expect_q.push_back(step_alarm(rq));
                requests_sent++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata[26:0]);
                if (alarm_expect_q.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing expected, expected none, actual %h",
                             $time, m_axis_tdata);
                end else begin
                    want = alarm_expect_q.pop_front();
                    results_checked++;
                    if (want.alarm_event) events_seen++;
                    if (want.level == LVL_THREE) level3_seen++;
                    check_field("level", want.level, got.level);
                    check_field("muted", want.muted, got.muted);
                    check_field("green_led", want.green_led, got.green_led);
                    check_field("red_led", want.red_led, got.red_led);
                    check_field("buzzer", want.buzzer, got.buzzer);
                    check_field("fan_percent", want.fan_percent, got.fan_percent);
                    check_field("alarm_event", want.alarm_event, got.alarm_event);
                    check_field("event_gas", want.event_gas, got.event_gas);
                    check_field("tdata pad", 0, m_axis_tdata[31:27]);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d requests and %0d results still open", $time,
                     alarm_req_q.size(), alarm_expect_q.size());
            $display("FAIL gas_temp_alarm_level_fsm_unit");
            $finish;
        end
    end

    // One register write over the configuration port: a setup phase, then an access
    // phase at whose close the register takes the value.
    task automatic write_threshold(logic [2:0] idx, logic [15:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'h0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_WARN_ENTER:     thr_warn_enter = val[11:0];
            REG_DANGER_ENTER:   thr_danger_enter = val[11:0];
            REG_CRITICAL_ENTER: thr_crit_enter = val[11:0];
            REG_CRITICAL_EXIT:  thr_crit_exit = val[11:0];
            REG_DANGER_EXIT:    thr_danger_exit = val[11:0];
            REG_WARN_EXIT:      thr_warn_exit = val[11:0];
            REG_TEMP_WARN:      thr_temp_warn = val;
            default:            thr_temp_danger = val;
        endcase
    endtask

    task automatic load_thresholds(int we, int de, int ce, int cx, int dx, int wx,
                                   int tw, int td);
        write_threshold(REG_WARN_ENTER, 16'(we));
        write_threshold(REG_DANGER_ENTER, 16'(de));
        write_threshold(REG_CRITICAL_ENTER, 16'(ce));
        write_threshold(REG_CRITICAL_EXIT, 16'(cx));
        write_threshold(REG_DANGER_EXIT, 16'(dx));
        write_threshold(REG_WARN_EXIT, 16'(wx));
        write_threshold(REG_TEMP_WARN, 16'(tw));
        write_threshold(REG_TEMP_DANGER, 16'(td));
        settings_used++;
    endtask

    function automatic void add_req(t_cmd c, int gas, int temp, logic [31:0] up);
        t_alarm_req rq;
        rq.cmd = c;
        rq.gas = 12'(gas);
        rq.temp = 16'(temp);
        rq.uptime = up;
        alarm_req_q.push_back(rq);
    endfunction

    // Gas readings cluster around the thresholds in force so that the hysteresis
    // edges are hit from both sides; the rest are extremes or anywhere in range.
    function automatic int pick_gas();
        int g;
        case ($urandom_range(0, 10))
            0: g = thr_warn_enter;
            1: g = thr_danger_enter;
            2: g = thr_crit_enter;
            3: g = thr_crit_exit;
            4: g = thr_danger_exit;
            5: g = thr_warn_exit;
            6: g = ATTN_ENTER;
            7: g = ATTN_EXIT;
            8: return $urandom_range(0, 1) ? 4095 : 0;
            default: return $urandom_range(0, 4095);
        endcase
        g = g + int'($urandom_range(0, 4)) - 2;
        if (g < 0) g = 0;
        if (g > 4095) g = 4095;
        return g;
    endfunction

    function automatic int pick_temp();
        int t;
        case ($urandom_range(0, 5))
            0: t = thr_temp_warn;
            1: t = thr_temp_danger;
            2: return $urandom_range(0, 1) ? 32767 : -32768;
            default: return int'($signed(16'($urandom)));
        endcase
        t = t + int'($urandom_range(0, 4)) - 2;
        if (t < -32768) t = -32768;
        if (t > 32767) t = 32767;
        return t;
    endfunction

    // Mostly past the startup hold, so that the level logic is really exercised.
    function automatic logic [31:0] pick_uptime();
        case ($urandom_range(0, 19))
            0: return $urandom_range(0, HOLD_MS - 1);
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'd0;
                    1: return 32'(HOLD_MS - 1);
                    2: return 32'(HOLD_MS);
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom_range(HOLD_MS, 32'hFFFF_FFFF);
        endcase
    endfunction

    function automatic t_cmd pick_cmd();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) return CMD_EVAL;
        if (r < 88) return CMD_MUTE;
        if (r < 95) return CMD_RESET;
        return CMD_FORCE;
    endfunction

    // Random requests. Part of them come as runs of critical readings, which are
    // needed to confirm level3 and to drive the count into saturation, often
    // followed by a mute key.
    task automatic queue_random(int n);
        int made;
        int run;
        made = 0;
        while (made < n) begin
            if ($urandom_range(0, 99) < 12) begin
                run = $urandom_range(1, 14);
                repeat (run) begin
                    add_req(CMD_EVAL, $urandom_range(thr_crit_enter, 4095), pick_temp(),
                            $urandom_range(HOLD_MS, 32'hFFFF_FFFF));
                end
                made += run;
                if ($urandom_range(0, 1)) begin
                    add_req(CMD_MUTE, pick_gas(), pick_temp(), pick_uptime());
                    made++;
                end
            end else begin
                add_req(pick_cmd(), pick_gas(), pick_temp(), pick_uptime());
                made++;
            end
        end
    endtask

    // Waits until every request has been taken and every result has come back,
    // then lets the pipeline settle before anything else happens.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (alarm_req_q.size() != 0 || s_axis_tvalid || alarm_expect_q.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic run_random(int n);
        queue_random(n);
        wait_drained();
    endtask

    initial begin
        // Shadow state at reset: default thresholds, level none, all flags clear.
        thr_warn_enter = 12'd300;
        thr_danger_enter = 12'd500;
        thr_crit_enter = 12'd700;
        thr_crit_exit = 12'd650;
        thr_danger_exit = 12'd450;
        thr_warn_exit = 12'd250;
        thr_temp_warn = 16'sd450;
        thr_temp_danger = 16'sd600;
        st_level = LVL_NONE;
        st_count = '0;
        st_forced = 1'b0;
        st_muted = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed walk with the default thresholds: the startup hold, each level entered
        // and held by hysteresis, the temperature path, level3 confirmation, mute below
        // and at level3, forced emergency and admin reset, with the field extremes.
        add_req(CMD_EVAL, 4095, 32767, 32'd0);
        add_req(CMD_EVAL, 800, 0, 32'(HOLD_MS - 1));
        add_req(CMD_EVAL, 0, -32768, 32'(HOLD_MS));
        add_req(CMD_EVAL, 200, 0, 32'd40000);
        add_req(CMD_EVAL, 190, 0, 32'd40001);
        add_req(CMD_EVAL, 300, 0, 32'd40002);
        add_req(CMD_EVAL, 260, 0, 32'd40003);
        add_req(CMD_EVAL, 100, 450, 32'd40004);
        add_req(CMD_EVAL, 100, 600, 32'd40005);
        add_req(CMD_EVAL, 460, 0, 32'd40006);
        add_req(CMD_MUTE, 0, 0, 32'd40007);
        add_req(CMD_EVAL, 700, 0, 32'd40008);
        add_req(CMD_EVAL, 700, 0, 32'd40009);
        add_req(CMD_EVAL, 4095, 0, 32'd40010);
        add_req(CMD_MUTE, 0, 0, 32'd40011);
        add_req(CMD_EVAL, 660, 0, 32'd40012);
        add_req(CMD_EVAL, 4095, 0, 32'd40013);
        add_req(CMD_EVAL, 650, 0, 32'd40014);
        add_req(CMD_FORCE, 0, 0, 32'd40015);
        add_req(CMD_EVAL, 0, 0, 32'd0);
        add_req(CMD_MUTE, 0, 0, 32'd40016);
        add_req(CMD_FORCE, 4095, 0, 32'd40017);
        add_req(CMD_RESET, 4095, 32767, 32'hFFFF_FFFF);
        add_req(CMD_EVAL, 4095, -1, 32'hFFFF_FFFF);
        add_req(CMD_RESET, 0, 0, 32'd0);
        wait_drained();

        // Random traffic on the default thresholds, with both sides idling at random.
        run_random(300);

        // Lowest thresholds: every reading counts as critical.
        load_thresholds(0, 0, 0, 0, 0, 0, -32768, -32768);
        run_random(150);

        // Highest thresholds: only the top gas code and temperature reach the upper levels.
        load_thresholds(4095, 4095, 4095, 4095, 4095, 4095, 32767, 32767);
        run_random(150);

        // Random but ordered thresholds. The sender offers back to back while the
        // receiver holds off once for a long stretch, filling the pipeline.
        begin
            int wx, we, dx, de, cx, ce, tw, td;
            wx = $urandom_range(150, 1000);
            we = wx + $urandom_range(0, 60);
            dx = we + $urandom_range(0, 200);
            de = dx + $urandom_range(0, 60);
            cx = de + $urandom_range(0, 200);
            ce = cx + $urandom_range(0, 60);
            tw = int'($urandom_range(0, 1000)) - 500;
            td = tw + $urandom_range(0, 300);
            load_thresholds(we, de, ce, cx, dx, wx, tw, td);
        end
        tx_idle_en = 1'b0;
        hold_request = 1'b1;
        run_random(300);
        tx_idle_en = 1'b1;

        // Unordered thresholds, used just as written.
        load_thresholds($urandom_range(0, 4095), $urandom_range(0, 4095),
                        $urandom_range(0, 4095), $urandom_range(0, 4095),
                        $urandom_range(0, 4095), $urandom_range(0, 4095),
                        int'($signed(16'($urandom))), int'($signed(16'($urandom))));
        run_random(200);

        // Back to the default thresholds for the last part, with no idling on either side.
        load_thresholds(300, 500, 700, 650, 450, 250, 450, 600);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_random(300);

        $display("Checked %0d results for %0d requests over %0d threshold settings.",
                 results_checked, requests_sent, settings_used);
        $display("Saw %0d alarm events and %0d results at level3; long output stall %s.",
                 events_seen, level3_seen, hold_done ? "done" : "missed");
        if (errors == 0) begin
            $display("PASS gas_temp_alarm_level_fsm_unit");
        end else begin
            $display("FAIL gas_temp_alarm_level_fsm_unit");
        end
        $finish;
    end

endmodule
